// ----- rtl/fnpll_pkg.sv -----
package fnpll_pkg;

    // field widths
    localparam int FREQ_W  = 20;
    localparam int CH_W    = 2;
    localparam int WORD_W  = 32;
    localparam int PAUSE_W = 2;
    localparam int DIVC_W  = 6;
    localparam int NUM_W   = 22;
    localparam int QUOT_W  = 7;
    localparam int NWORDS  = 5;

    localparam int MAX_DIVIDER_STEP_DEF = 18;

    // vco window and divide-by-3072 helpers
    localparam int unsigned VCO_LOW  = 188000;
    localparam int unsigned VCO_HIGH = 376000;
    localparam logic [16:0] RECIP3   = 17'd171;
    localparam logic [NUM_W-1:0] FRAC_SCALE = 22'd1000;

    // fixed register words
    localparam logic [WORD_W-1:0] FRAC_DEN   = 32'h002e_e000;
    localparam logic [WORD_W-1:0] R5_MUXED   = 32'h0010_A805;
    localparam logic [WORD_W-1:0] R5_BYPASS  = 32'h0010_8005;
    localparam logic [WORD_W-1:0] R3_BASE    = 32'h2000_0FE3;
    localparam logic [WORD_W-1:0] R2_WORD    = 32'h0c00_0002 | (FRAC_DEN << 4);
    localparam logic [WORD_W-1:0] R1_BASE    = 32'h7000_2021;
    localparam logic [WORD_W-1:0] R0_BASE    = 32'h4000_0000;
    localparam logic [WORD_W-1:0] INIT_W0    = 32'h0010_8015;
    localparam logic [WORD_W-1:0] INIT_W1    = 32'h021F_E80F;
    localparam logic [WORD_W-1:0] INIT_W2    = 32'h4082_C10D;
    localparam logic [WORD_W-1:0] INIT_W3    = 32'h2100_50CA;
    localparam logic [WORD_W-1:0] INIT_W4    = 32'h03C7_C039;
    localparam logic [WORD_W-1:0] INIT_W5    = 32'h207D_DBF8;
    localparam logic [WORD_W-1:0] INIT_W6    = 32'h0008_2317;
    localparam logic [WORD_W-1:0] INIT_W7    = 32'h0000_04C6;
    localparam logic [WORD_W-1:0] FIX_W9     = 32'h0000_0004;

    // computed word slots
    localparam int SLOT_R5 = 0;
    localparam int SLOT_R3 = 1;
    localparam int SLOT_R2 = 2;
    localparam int SLOT_R1 = 3;
    localparam int SLOT_R0 = 4;

    // pause codes
    localparam logic [PAUSE_W-1:0] PAUSE_NONE   = 2'd0;
    localparam logic [PAUSE_W-1:0] PAUSE_SETTLE = 2'd1;
    localparam logic [PAUSE_W-1:0] PAUSE_LOCK   = 2'd2;

    // microprogram geometry
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] A_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] A_TEST0 = 5'd1;
    localparam logic [PC_W-1:0] A_DBL   = 5'd2;
    localparam logic [PC_W-1:0] A_LOOP  = 5'd3;
    localparam logic [PC_W-1:0] A_CHECK = 5'd4;
    localparam logic [PC_W-1:0] A_ERR   = 5'd5;
    localparam logic [PC_W-1:0] A_CALCQ = 5'd6;
    localparam logic [PC_W-1:0] A_CALCN = 5'd7;
    localparam logic [PC_W-1:0] A_SAVE  = 5'd8;
    localparam logic [PC_W-1:0] A_EMIT0 = 5'd9;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_DBL    = 2'd2,
        ACC_SEARCH = 2'd3
    } t_acc;

    typedef enum logic [1:0] {
        C_NEXT   = 2'd0,
        C_JUMP   = 2'd1,
        C_IN_WIN = 2'd2,
        C_SEARCH = 2'd3
    } t_cond;

    typedef enum logic [3:0] {
        WS_ZERO  = 4'd0,
        WS_INIT0 = 4'd1,
        WS_INIT1 = 4'd2,
        WS_INIT2 = 4'd3,
        WS_INIT3 = 4'd4,
        WS_INIT4 = 4'd5,
        WS_INIT5 = 4'd6,
        WS_INIT6 = 4'd7,
        WS_INIT7 = 4'd8,
        WS_R5    = 4'd9,
        WS_FIX9  = 4'd10,
        WS_R3    = 4'd11,
        WS_R2    = 4'd12,
        WS_R1    = 4'd13,
        WS_R0    = 4'd14
    } t_wsel;

    // one control word
    typedef struct packed {
        logic                wait_in;
        logic                wait_out;
        t_acc                acc;
        logic                calc_q;
        logic                calc_num;
        logic                save;
        logic                emit;
        t_wsel               wsel;
        logic [PAUSE_W-1:0]  pause;
        logic                err;
        logic                last;
        t_cond               cond;
        logic [PC_W-1:0]     target;
    } t_uop;

    // sequencer to datapath
    typedef struct packed {
        t_acc                acc;
        logic                calc_q;
        logic                calc_num;
        logic                save;
        logic                emit;
        t_wsel               wsel;
        logic [PAUSE_W-1:0]  pause;
        logic                err;
        logic                last;
    } t_dp_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic in_win;
        logic step_max;
        logic out_free;
    } t_dp_sts;

    function automatic t_uop mk_emit(input t_wsel wsel, input logic [PAUSE_W-1:0] pause,
                                     input logic last);
        t_uop u;
        u          = '0;
        u.wait_out = 1'b1;
        u.emit     = 1'b1;
        u.wsel     = wsel;
        u.pause    = pause;
        u.last     = last;
        u.cond     = C_NEXT;
        if (last) begin
            u.cond = C_JUMP;
        end
        u.target   = A_IDLE;
        return u;
    endfunction

    // microprogram rom
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        unique case (pc)
            A_IDLE: begin
                u.wait_in = 1'b1;
                u.acc     = ACC_LOAD;
            end
            A_TEST0: begin
                u.cond   = C_IN_WIN;
                u.target = A_CALCQ;
            end
            A_DBL: begin
                u.acc = ACC_DBL;
            end
            A_LOOP: begin
                u.acc    = ACC_SEARCH;
                u.cond   = C_SEARCH;
                u.target = A_LOOP;
            end
            A_CHECK: begin
                u.cond   = C_IN_WIN;
                u.target = A_CALCQ;
            end
            A_ERR: begin
                u          = mk_emit(WS_ZERO, PAUSE_NONE, 1'b1);
                u.err      = 1'b1;
            end
            A_CALCQ: u.calc_q   = 1'b1;
            A_CALCN: u.calc_num = 1'b1;
            A_SAVE:  u.save     = 1'b1;
            A_EMIT0:         u = mk_emit(WS_INIT0, PAUSE_SETTLE, 1'b0);
            A_EMIT0 + 5'd1:  u = mk_emit(WS_INIT1, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd2:  u = mk_emit(WS_INIT2, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd3:  u = mk_emit(WS_INIT3, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd4:  u = mk_emit(WS_INIT4, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd5:  u = mk_emit(WS_INIT5, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd6:  u = mk_emit(WS_INIT6, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd7:  u = mk_emit(WS_INIT7, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd8:  u = mk_emit(WS_R5, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd9:  u = mk_emit(WS_FIX9, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd10: u = mk_emit(WS_R3, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd11: u = mk_emit(WS_R2, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd12: u = mk_emit(WS_R1, PAUSE_NONE, 1'b0);
            A_EMIT0 + 5'd13: u = mk_emit(WS_R0, PAUSE_LOCK, 1'b0);
            A_EMIT0 + 5'd14: u = mk_emit(WS_R0, PAUSE_NONE, 1'b1);
            default: begin
                u.cond   = C_JUMP;
                u.target = A_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/fnpll_useq.sv -----
module fnpll_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fnpll_pkg::t_dp_sts  i_sts,
    output fnpll_pkg::t_dp_ctl  o_ctl
);

    logic [fnpll_pkg::PC_W-1:0] r_pc;
    logic [fnpll_pkg::PC_W-1:0] n_pc;
    fnpll_pkg::t_uop            uop;
    logic                       hold;

    // fetch the control word
    assign uop  = fnpll_pkg::uop_rom(r_pc);
    assign hold = (uop.wait_in && !i_in_valid) || (uop.wait_out && !i_sts.out_free);

    // no input transaction while in reset
    assign o_in_stall = !uop.wait_in || !i_rst_n;

    // gate datapath actions while waiting
    always_comb begin
        if (hold) begin
            o_ctl.acc = fnpll_pkg::ACC_HOLD;
        end else begin
            o_ctl.acc = uop.acc;
        end
        o_ctl.calc_q   = uop.calc_q && !hold;
        o_ctl.calc_num = uop.calc_num && !hold;
        o_ctl.save     = uop.save && !hold;
        o_ctl.emit     = uop.emit && !hold;
        o_ctl.wsel     = uop.wsel;
        o_ctl.pause    = uop.pause;
        o_ctl.err      = uop.err;
        o_ctl.last     = uop.last;
    end

    // next step
    always_comb begin
        n_pc = r_pc + fnpll_pkg::PC_W'(1);
        if (hold) begin
            n_pc = r_pc;
        end else begin
            unique case (uop.cond)
                fnpll_pkg::C_NEXT:   n_pc = r_pc + fnpll_pkg::PC_W'(1);
                fnpll_pkg::C_JUMP:   n_pc = uop.target;
                fnpll_pkg::C_IN_WIN: begin
                    if (i_sts.in_win) n_pc = uop.target;
                end
                fnpll_pkg::C_SEARCH: begin
                    if (!i_sts.in_win && !i_sts.step_max) n_pc = uop.target;
                end
                default: n_pc = fnpll_pkg::A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fnpll_pkg::A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- rtl/fnpll_dpath.sv -----
module fnpll_dpath #(
    parameter int MAX_DIVIDER_STEP = fnpll_pkg::MAX_DIVIDER_STEP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fnpll_pkg::t_dp_ctl            i_ctl,
    output fnpll_pkg::t_dp_sts            o_sts,
    input  logic [fnpll_pkg::FREQ_W-1:0]  i_freq_units,
    input  logic [fnpll_pkg::CH_W-1:0]    i_channel,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [fnpll_pkg::WORD_W-1:0]  o_spi_word,
    output logic [fnpll_pkg::CH_W-1:0]    o_select_channel,
    output logic [fnpll_pkg::PAUSE_W-1:0] o_pause_after,
    output logic                          o_range_error,
    output logic                          o_last_word
);

    localparam int STEP_W = (MAX_DIVIDER_STEP < 2) ? 1 : $clog2(MAX_DIVIDER_STEP + 1);
    localparam int VCO_W  = fnpll_pkg::FREQ_W + $clog2(2 * MAX_DIVIDER_STEP + 3);

    logic [fnpll_pkg::FREQ_W-1:0] r_freq;
    logic [fnpll_pkg::CH_W-1:0]   r_chan;
    logic [VCO_W-1:0]             r_vco;
    logic [STEP_W-1:0]            r_step;
    logic                         r_muxed;
    logic [fnpll_pkg::QUOT_W-1:0] r_quot;
    logic [fnpll_pkg::NUM_W-1:0]  r_num;
    logic [fnpll_pkg::WORD_W-1:0] r_words [fnpll_pkg::NWORDS];

    logic                         r_out_valid;
    logic [fnpll_pkg::WORD_W-1:0] r_spi_word;
    logic [fnpll_pkg::CH_W-1:0]   r_sel;
    logic [fnpll_pkg::PAUSE_W-1:0] r_pause;
    logic                         r_err;
    logic                         r_last;

    logic [VCO_W-1:0]             dbl;
    logic [8:0]                   vco_hi;
    logic [16:0]                  prod;
    logic [8:0]                   three_q;
    logic [8:0]                   diff;
    logic [11:0]                  rem;
    logic [fnpll_pkg::WORD_W-1:0] word;
    logic [fnpll_pkg::DIVC_W-1:0] divc;

    // window and loop status
    assign dbl            = VCO_W'({r_freq, 1'b0});
    assign o_sts.in_win   = (r_vco >= VCO_W'(fnpll_pkg::VCO_LOW)) &&
                            (r_vco <= VCO_W'(fnpll_pkg::VCO_HIGH));
    assign o_sts.step_max = (r_step == STEP_W'(MAX_DIVIDER_STEP));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // vco / 3072 as (vco >> 10) / 3 by reciprocal, remainder by subtract
    assign vco_hi  = r_vco[18:10];
    assign prod    = {8'd0, vco_hi} * fnpll_pkg::RECIP3;
    assign three_q = {1'b0, r_quot, 1'b0} + {2'b00, r_quot};
    assign diff    = vco_hi - three_q;
    assign rem     = {diff[1:0], r_vco[9:0]};
    assign divc    = fnpll_pkg::DIVC_W'(r_step);

    // search accumulator
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.acc)
            fnpll_pkg::ACC_HOLD: begin
            end
            fnpll_pkg::ACC_LOAD: begin
                r_freq  <= i_freq_units;
                r_chan  <= i_channel;
                r_vco   <= VCO_W'(i_freq_units);
                r_step  <= '0;
                r_muxed <= 1'b0;
            end
            fnpll_pkg::ACC_DBL: begin
                r_vco   <= dbl;
                r_step  <= '0;
                r_muxed <= 1'b1;
            end
            fnpll_pkg::ACC_SEARCH: begin
                if (!o_sts.in_win && !o_sts.step_max) begin
                    r_vco  <= r_vco + dbl;
                    r_step <= r_step + STEP_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // integer and fractional parts, then the computed words
    always_ff @(posedge i_clk) begin
        if (i_ctl.calc_q) begin
            r_quot <= prod[15:9];
        end
        if (i_ctl.calc_num) begin
            r_num <= fnpll_pkg::NUM_W'(rem) * fnpll_pkg::FRAC_SCALE;
        end
        if (i_ctl.save) begin
            r_words[fnpll_pkg::SLOT_R5] <= r_muxed ? fnpll_pkg::R5_MUXED : fnpll_pkg::R5_BYPASS;
            r_words[fnpll_pkg::SLOT_R3] <= fnpll_pkg::R3_BASE | {8'd0, divc, 18'd0};
            r_words[fnpll_pkg::SLOT_R2] <= fnpll_pkg::R2_WORD;
            r_words[fnpll_pkg::SLOT_R1] <= fnpll_pkg::R1_BASE | {7'd0, r_num[21:12], 15'd0};
            r_words[fnpll_pkg::SLOT_R0] <= fnpll_pkg::R0_BASE |
                                           {4'd0, 5'd0, r_quot, r_num[11:0], 4'd0};
        end
    end

    // word select
    always_comb begin
        unique case (i_ctl.wsel)
            fnpll_pkg::WS_ZERO:  word = '0;
            fnpll_pkg::WS_INIT0: word = fnpll_pkg::INIT_W0;
            fnpll_pkg::WS_INIT1: word = fnpll_pkg::INIT_W1;
            fnpll_pkg::WS_INIT2: word = fnpll_pkg::INIT_W2;
            fnpll_pkg::WS_INIT3: word = fnpll_pkg::INIT_W3;
            fnpll_pkg::WS_INIT4: word = fnpll_pkg::INIT_W4;
            fnpll_pkg::WS_INIT5: word = fnpll_pkg::INIT_W5;
            fnpll_pkg::WS_INIT6: word = fnpll_pkg::INIT_W6;
            fnpll_pkg::WS_INIT7: word = fnpll_pkg::INIT_W7;
            fnpll_pkg::WS_R5:    word = r_words[fnpll_pkg::SLOT_R5];
            fnpll_pkg::WS_FIX9:  word = fnpll_pkg::FIX_W9;
            fnpll_pkg::WS_R3:    word = r_words[fnpll_pkg::SLOT_R3];
            fnpll_pkg::WS_R2:    word = r_words[fnpll_pkg::SLOT_R2];
            fnpll_pkg::WS_R1:    word = r_words[fnpll_pkg::SLOT_R1];
            fnpll_pkg::WS_R0:    word = r_words[fnpll_pkg::SLOT_R0];
            default:             word = '0;
        endcase
    end

    // output transaction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_spi_word <= word;
            r_sel      <= r_chan;
            r_pause    <= i_ctl.pause;
            r_err      <= i_ctl.err;
            r_last     <= i_ctl.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_spi_word       = r_spi_word;
    assign o_select_channel = r_sel;
    assign o_pause_after    = r_pause;
    assign o_range_error    = r_err;
    assign o_last_word      = r_last;

endmodule

// ----- rtl/frac_n_pll_register_programmer.sv -----
// the input frequency is used as the vco when it is already in the vco window; otherwise
// multiplier 2 * step + 2 is searched for, and the range error word is emitted when
// MAX_DIVIDER_STEP is reached with the vco still outside the window; output stalls hold the sequence
// a new request is taken only in the idle step, after the last word of the previous one,
// so requests do not overlap; the microprogram has a one-step search loop, three calc steps
// and fifteen emit steps
// reset: synchronous active low; clears the microprogram step and the output valid
module frac_n_pll_register_programmer #(
    parameter int MAX_DIVIDER_STEP = fnpll_pkg::MAX_DIVIDER_STEP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fnpll_pkg::FREQ_W-1:0]  i_freq_units,
    input  logic [fnpll_pkg::CH_W-1:0]    i_channel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fnpll_pkg::WORD_W-1:0]  o_spi_word,
    output logic [fnpll_pkg::CH_W-1:0]    o_select_channel,
    output logic [fnpll_pkg::PAUSE_W-1:0] o_pause_after,
    output logic                          o_range_error,
    output logic                          o_last_word
);

    fnpll_pkg::t_dp_ctl ctl;
    fnpll_pkg::t_dp_sts sts;

    // microprogram sequencer
    fnpll_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // search, divide and word datapath
    fnpll_dpath #(
        .MAX_DIVIDER_STEP (MAX_DIVIDER_STEP)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_freq_units     (i_freq_units),
        .i_channel        (i_channel),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_spi_word       (o_spi_word),
        .o_select_channel (o_select_channel),
        .o_pause_after    (o_pause_after),
        .o_range_error    (o_range_error),
        .o_last_word      (o_last_word)
    );

endmodule
